// ===== src/hks_pkg.sv =====
// ---------------------------------------------------------------------------
// hks_pkg
// Shared types and constants for the homography Kalman smoother.
// ---------------------------------------------------------------------------
package hks_pkg;

  localparam int N_ENTRY   = 9;
  localparam int IDX_W     = $clog2(N_ENTRY);
  localparam int DATA_W    = 32;
  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;
  localparam int GAIN_W    = FRAC_W + 1;

  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(1 << FRAC_W);

  localparam logic [REG_W-1:0] PROCESS_NOISE_RST      = REG_W'(655);
  localparam logic [REG_W-1:0] MEASUREMENT_NOISE_RST  = REG_W'(6554);
  localparam logic [REG_W-1:0] INITIAL_COVARIANCE_RST = REG_W'(65536);

  // shared divider: 4 quotient bits per cycle
  localparam int DIV_DVD_W  = 52;
  localparam int DIV_DVS_W  = DATA_W + 1;
  localparam int DIV_STEP   = 4;
  localparam int DIV_ITER   = DIV_DVD_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

  // shared multiplier
  localparam int MUL_A_W = DATA_W + 2;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE      = 2'd0,
    REG_MEASUREMENT_NOISE  = 2'd1,
    REG_INITIAL_COVARIANCE = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_GAIN,
    ST_GDIV,
    ST_NORM,
    ST_NDIV,
    ST_UMUL,
    ST_UWB,
    ST_CMUL,
    ST_CWB,
    ST_FRD,
    ST_FCAP,
    ST_DONE
  } state_t;

endpackage

// ===== src/hks_ram.sv =====
// ---------------------------------------------------------------------------
// hks_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module hks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hks_div.sv =====
// ---------------------------------------------------------------------------
// hks_div
// Unsigned restoring divider, several quotient bits per cycle.
// ---------------------------------------------------------------------------
module hks_div import hks_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_DVS_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_ITER - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DVS_W:0]   rem;
  logic [DIV_DVD_W-1:0] quo;
  logic [DIV_DVS_W-1:0] dvs;
  logic [DIV_DVS_W:0]   rem_next;
  logic [DIV_DVD_W-1:0] quo_next;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < DIV_STEP; k++) begin
      rem_next = {rem_next[DIV_DVS_W-1:0], quo_next[DIV_DVD_W-1]};
      quo_next = {quo_next[DIV_DVD_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next    = rem_next - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= CNT_LAST)
    else $error("divider step count out of range");

endmodule

// ===== src/homography_kalman_smoother.sv =====
// ---------------------------------------------------------------------------
// homography_kalman_smoother
// Normalizes a Q16.16 homography by h22 and smooths all nine entries with
// one shared random-walk Kalman covariance.
// The shared divider computes the gain and then each of the nine entries;
// a zero h22 skips it. A new beat is taken only in idle, once the previous
// result has been loaded into the output register.
// The estimate lives in a 9-entry RAM; the next beat is taken while a result
// waits in the output register.
// Reset: registers to defaults, primed cleared (next estimate seeds from input).
// ---------------------------------------------------------------------------
module homography_kalman_smoother import hks_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] h00,
  input  logic signed [DATA_W-1:0] h01,
  input  logic signed [DATA_W-1:0] h02,
  input  logic signed [DATA_W-1:0] h10,
  input  logic signed [DATA_W-1:0] h11,
  input  logic signed [DATA_W-1:0] h12,
  input  logic signed [DATA_W-1:0] h20,
  input  logic signed [DATA_W-1:0] h21,
  input  logic signed [DATA_W-1:0] h22,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] s00,
  output logic signed [DATA_W-1:0] s01,
  output logic signed [DATA_W-1:0] s02,
  output logic signed [DATA_W-1:0] s10,
  output logic signed [DATA_W-1:0] s11,
  output logic signed [DATA_W-1:0] s12,
  output logic signed [DATA_W-1:0] s20,
  output logic signed [DATA_W-1:0] s21,
  output logic signed [DATA_W-1:0] s22,
  output logic                     divide_fault
);

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(N_ENTRY - 1);
  localparam int                SUM_W    = MUL_P_W - FRAC_W + 1;
  localparam logic [DATA_W-1:0] INT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] INT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  logic [REG_W-1:0] process_noise;
  logic [REG_W-1:0] measurement_noise;
  logic [REG_W-1:0] initial_covariance;

  state_t state, state_next;

  logic [DATA_W-1:0]        h [N_ENTRY];
  logic [IDX_W-1:0]         idx;
  logic                     primed;
  logic [DATA_W-1:0]        cov;
  logic [DATA_W-1:0]        p;
  logic [DATA_W:0]          den;
  logic [GAIN_W-1:0]        gain;
  logic signed [DATA_W-1:0] m_val;
  logic signed [DATA_W-1:0] e_val;
  logic signed [MUL_P_W-1:0] prod;
  logic [DATA_W-1:0]        res [N_ENTRY];
  logic                     res_fault;
  logic [DATA_W-1:0]        out_q [N_ENTRY];
  logic                     out_fault;

  // control
  logic accept;
  logic load;
  logic div_start;
  logic ram_we;

  // datapath
  logic [DATA_W-1:0]        p_base;
  logic [DATA_W:0]          p_sum;
  logic [DATA_W-1:0]        p_sat;
  logic [DATA_W:0]          den_next;
  logic [DATA_W-1:0]        mag_h;
  logic [DATA_W-1:0]        mag_d;
  logic [DIV_DVD_W-1:0]     div_dividend;
  logic [DIV_DVS_W-1:0]     div_divisor;
  logic                     div_done;
  logic [DIV_DVD_W-1:0]     div_quo;
  logic                     neg;
  logic [DATA_W-1:0]        m_div;
  logic [GAIN_W-1:0]        gain_div;
  logic signed [DATA_W:0]   diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] rnd;
  logic signed [SUM_W-1:0]  sum;
  logic [DATA_W-1:0]        e_new;
  logic [DATA_W-1:0]        rdata;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= PROCESS_NOISE_RST;
      measurement_noise  <= MEASUREMENT_NOISE_RST;
      initial_covariance <= INITIAL_COVARIANCE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROCESS_NOISE:      process_noise      <= cfg_data;
        REG_MEASUREMENT_NOISE:  measurement_noise  <= cfg_data;
        REG_INITIAL_COVARIANCE: initial_covariance <= cfg_data;
        default: ;
      endcase
    end
  end

  // covariance prediction
  assign p_base   = primed ? cov : DATA_W'(initial_covariance);
  assign p_sum    = {1'b0, p_base} + (DATA_W+1)'(process_noise);
  assign p_sat    = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
  assign den_next = {1'b0, p_sat} + (DATA_W+1)'(measurement_noise);

  // divider operands
  assign mag_h = mag(h[idx]);
  assign mag_d = mag(h[N_ENTRY-1]);

  always_comb begin
    if (state == ST_GAIN) begin
      div_dividend = DIV_DVD_W'({p, {FRAC_W{1'b0}}}) + DIV_DVD_W'(den >> 1);
      div_divisor  = den;
    end else begin
      div_dividend = DIV_DVD_W'({mag_h, {FRAC_W{1'b0}}}) + DIV_DVD_W'(mag_d >> 1);
      div_divisor  = {1'b0, mag_d};
    end
  end

  hks_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // signed, saturated normalized entry and clamped gain
  assign neg = h[idx][DATA_W-1] ^ h[N_ENTRY-1][DATA_W-1];

  always_comb begin
    if (neg) begin
      m_div = (div_quo > DIV_DVD_W'(INT_MIN)) ? INT_MIN : (~div_quo[DATA_W-1:0] + DATA_W'(1));
    end else begin
      m_div = (div_quo > DIV_DVD_W'(INT_MAX)) ? INT_MAX : div_quo[DATA_W-1:0];
    end
    gain_div = (div_quo > DIV_DVD_W'(ONE_Q16)) ? ONE_Q16 : div_quo[GAIN_W-1:0];
  end

  // shared multiplier
  assign diff = {m_val[DATA_W-1], m_val} - {e_val[DATA_W-1], e_val};

  always_comb begin
    if (state == ST_CMUL) begin
      mul_a = {2'b00, p};
      mul_b = {1'b0, ONE_Q16 - gain};
    end else begin
      mul_a = {diff[DATA_W], diff};
      mul_b = {1'b0, gain};
    end
  end

  assign rnd = prod + MUL_P_W'(1 << (FRAC_W - 1));
  assign sum = {{(SUM_W-DATA_W){e_val[DATA_W-1]}}, e_val}
             + {rnd[MUL_P_W-1], rnd[MUL_P_W-1:FRAC_W]};

  always_comb begin
    if (sum[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){sum[DATA_W-1]}}) begin
      e_new = sum[SUM_W-1] ? INT_MIN : INT_MAX;
    end else begin
      e_new = sum[DATA_W-1:0];
    end
  end

  // estimate store
  hks_ram #(
    .WIDTH (DATA_W),
    .DEPTH (N_ENTRY)
  ) u_est_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (e_new),
    .raddr (idx),
    .rdata (rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (h22 == '0) ? ST_FRD : ST_PRED;
        end
      end
      ST_PRED: state_next = ST_GAIN;
      ST_GAIN: begin
        if (den == '0) begin
          state_next = ST_NORM;
        end else begin
          div_start  = 1'b1;
          state_next = ST_GDIV;
        end
      end
      ST_GDIV: begin
        if (div_done) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        div_start  = 1'b1;
        state_next = ST_NDIV;
      end
      ST_NDIV: begin
        if (div_done) begin
          state_next = ST_UMUL;
        end
      end
      ST_UMUL: state_next = ST_UWB;
      ST_UWB: begin
        ram_we     = 1'b1;
        state_next = (idx == IDX_LAST) ? ST_CMUL : ST_NORM;
      end
      ST_CMUL: state_next = ST_CWB;
      ST_CWB:  state_next = ST_DONE;
      ST_FRD:  state_next = ST_FCAP;
      ST_FCAP: state_next = (idx == IDX_LAST) ? ST_DONE : ST_FRD;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        idx <= '0;
      end else if (state == ST_UWB || state == ST_FCAP) begin
        idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      end
      if (state == ST_CWB) begin
        primed <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      h[0]      <= h00;
      h[1]      <= h01;
      h[2]      <= h02;
      h[3]      <= h10;
      h[4]      <= h11;
      h[5]      <= h12;
      h[6]      <= h20;
      h[7]      <= h21;
      h[8]      <= h22;
      res_fault <= (h22 == '0);
    end
    if (state == ST_PRED) begin
      p   <= p_sat;
      den <= den_next;
    end
    if (state == ST_GAIN && den == '0) begin
      gain <= '0;
    end else if (state == ST_GDIV && div_done) begin
      gain <= gain_div;
    end
    if (state == ST_NDIV && div_done) begin
      m_val <= m_div;
      e_val <= primed ? rdata : m_div;
    end
    if (state == ST_UMUL || state == ST_CMUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_UWB) begin
      res[idx] <= e_new;
    end
    if (state == ST_FCAP) begin
      res[idx] <= primed ? rdata : '0;
    end
    if (state == ST_CWB) begin
      cov <= rnd[FRAC_W+DATA_W-1:FRAC_W];
    end
    if (load) begin
      out_q     <= res;
      out_fault <= res_fault;
    end
  end

  assign s00          = out_q[0];
  assign s01          = out_q[1];
  assign s02          = out_q[2];
  assign s10          = out_q[3];
  assign s11          = out_q[4];
  assign s12          = out_q[5];
  assign s20          = out_q[6];
  assign s21          = out_q[7];
  assign s22          = out_q[8];
  assign divide_fault = out_fault;

  a_primed_at_cov_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(primed) |-> $past(state) == ST_CWB)
    else $error("primed set outside covariance write-back");

  a_ram_idx_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> idx <= IDX_LAST)
    else $error("estimate write out of range");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NORM) |-> gain <= ONE_Q16)
    else $error("gain above one");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |=> state == ST_DONE)
    else $error("result overwritten while output beat pending");

endmodule
